[sv/cfic_pkg.sv]
// cfic_pkg: shared constants and types for the can frame intrusion checker
// holds table size, crc and tolerance constants, status codes, fsm state and
// the command/status structs between controller and datapath
package cfic_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [7:0] CRC_POLY = 8'hDA;
  localparam logic [3:0] MAX_CRC_BYTES = 4'd8;

  // period / 10 as (period * 0xcccd) >> 19, exact for 16-bit periods
  localparam logic [15:0] TOL_MUL = 16'hCCCD;
  localparam int TOL_SHIFT = 19;
  localparam int TOL_W = 32 - TOL_SHIFT;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNKNOWN = 3'd1,
    ST_LENGTH  = 3'd2,
    ST_COUNTER = 3'd3,
    ST_CRC     = 3'd4,
    ST_TIMING  = 3'd5,
    ST_WRITTEN = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_SCALE,
    S_DECIDE
  } state_t;

  typedef struct packed {
    logic load;
    logic run_step;
    logic scale;
    logic finish;
  } cfic_cmd_t;

  typedef struct packed {
    logic mode;
    logic search_fin;
    logic crc_fin;
    logic out_free;
  } cfic_sts_t;

endpackage

[sv/cfic_ctrl.sv]
// cfic_ctrl: sequencing state machine of the can frame intrusion checker
// depends on cfic_pkg; drives datapath commands from datapath status
module cfic_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cfic_pkg::cfic_sts_t sts,
  output cfic_pkg::cfic_cmd_t cmd
);
  import cfic_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (sts.mode) begin
          state_nxt = S_DECIDE;
        end else if (sts.search_fin && sts.crc_fin) begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_RUN: begin
        cmd.run_step = !sts.mode;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
      end
      S_DECIDE: begin
        cmd.finish = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> state_r == S_IDLE)
    else $error("finish did not return to idle");

  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> in_ready && state_r == S_IDLE)
    else $error("load outside idle");

  a_scale_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCALE |-> $past(state_r) == S_RUN && !sts.mode)
    else $error("scale not preceded by a check search");

endmodule

[sv/cfic_datapath.sv]
// cfic_datapath: message table, serial search, bytewise crc-8, timing window
// and result register of the can frame intrusion checker
// depends on cfic_pkg; commanded by cfic_ctrl
module cfic_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  cfic_pkg::cfic_cmd_t cmd,
  output cfic_pkg::cfic_sts_t sts,
  input  logic              in_mode,
  input  logic [3:0]        in_slot,
  input  logic [10:0]       in_frame_id,
  input  logic [3:0]        in_frame_len,
  input  logic [63:0]       in_frame_data,
  input  logic [31:0]       in_now_ms,
  input  logic [10:0]       in_new_id,
  input  logic [3:0]        in_new_len,
  input  logic [15:0]       in_new_period,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_status,
  output logic [3:0]        out_hit_slot,
  output logic [7:0]        out_expected_value,
  output logic [7:0]        out_crc_residue
);
  import cfic_pkg::*;

  function automatic logic [7:0] crc8_byte(input logic [7:0] r_in, input logic [7:0] d);
    logic [7:0] r;
    r = r_in ^ d;
    for (int k = 0; k < 8; k++) begin
      r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  // message table
  logic              valid_r  [ENTRIES];
  logic [10:0]       ident_r  [ENTRIES];
  logic [3:0]        length_r [ENTRIES];
  logic [15:0]       period_r [ENTRIES];
  logic [7:0]        seq_r    [ENTRIES];
  logic [31:0]       last_r   [ENTRIES];

  // item registers
  logic              mode_r;
  logic [3:0]        slot_r;
  logic [10:0]       fid_r;
  logic [3:0]        flen_r;
  logic [7:0]        byte0_r;
  logic [63:0]       crc_sh_r;
  logic [31:0]       now_r;
  logic [10:0]       nid_r;
  logic [3:0]        nlen_r;
  logic [15:0]       nper_r;

  // search and crc progress
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  hit_r;
  logic              found_r;
  logic              all_r;
  logic [3:0]        crc_cnt_r;
  logic [3:0]        crc_total_r;
  logic [7:0]        crc_r;

  // timing window
  logic [TOL_W-1:0]  tol_r;
  logic [32:0]       exp_r;

  // result register
  logic              out_valid_r;
  status_t           status_r;
  logic [3:0]        hit_out_r;
  logic [7:0]        expv_r;
  logic [7:0]        res_r;

  logic              search_fin;
  logic              crc_fin;
  logic              idx_match;
  logic [IDX_W-1:0]  slot_idx;
  logic              slot_in_range;
  logic [31:0]       tol_prod;
  logic [33:0]       win_lo;
  logic [33:0]       win_hi;
  logic              time_ok;
  logic              commit;
  status_t           status_nxt;
  logic [3:0]        hit_out_nxt;
  logic [7:0]        expv_nxt;
  logic [7:0]        res_nxt;

  assign search_fin    = found_r || all_r;
  assign crc_fin       = crc_cnt_r == crc_total_r;
  assign idx_match     = valid_r[idx_r] && (ident_r[idx_r] == fid_r);
  assign slot_idx      = IDX_W'(slot_r);
  assign slot_in_range = 32'(slot_r) < ENTRIES;
  assign tol_prod      = 32'(period_r[hit_r]) * 32'(TOL_MUL);

  assign sts.mode       = mode_r;
  assign sts.search_fin = search_fin;
  assign sts.crc_fin    = crc_fin;
  assign sts.out_free   = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      all_r   <= 1'b0;
    end else if (cmd.load) begin
      found_r <= 1'b0;
      all_r   <= 1'b0;
    end else if (cmd.run_step && !search_fin) begin
      if (idx_match) begin
        found_r <= 1'b1;
      end
      if (idx_r == IDX_W'(ENTRIES - 1)) begin
        all_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r      <= in_mode;
      slot_r      <= in_slot;
      fid_r       <= in_frame_id;
      flen_r      <= in_frame_len;
      byte0_r     <= in_frame_data[7:0];
      crc_sh_r    <= in_frame_data;
      now_r       <= in_now_ms;
      nid_r       <= in_new_id;
      nlen_r      <= in_new_len;
      nper_r      <= in_new_period;
      idx_r       <= '0;
      hit_r       <= '0;
      crc_cnt_r   <= '0;
      crc_total_r <= (in_frame_len > MAX_CRC_BYTES) ? MAX_CRC_BYTES : in_frame_len;
      crc_r       <= '0;
    end else if (cmd.run_step) begin
      if (!search_fin) begin
        idx_r <= idx_r + IDX_W'(1);
        if (idx_match) begin
          hit_r <= idx_r;
        end
      end
      if (!crc_fin) begin
        crc_r     <= crc8_byte(crc_r, crc_sh_r[7:0]);
        crc_sh_r  <= crc_sh_r >> 8;
        crc_cnt_r <= crc_cnt_r + 4'd1;
      end
    end
    if (cmd.scale) begin
      tol_r <= tol_prod[31:TOL_SHIFT];
      exp_r <= 33'(last_r[hit_r]) + 33'(period_r[hit_r]);
    end
  end

  assign win_lo  = 34'(exp_r) - 34'(tol_r);
  assign win_hi  = 34'(exp_r) + 34'(tol_r);
  assign time_ok = (last_r[hit_r] == 32'd0) ||
                   ((34'(now_r) > win_lo) && (34'(now_r) < win_hi));

  always_comb begin
    status_nxt  = ST_OK;
    hit_out_nxt = '0;
    expv_nxt    = '0;
    res_nxt     = '0;
    commit      = 1'b0;
    if (mode_r) begin
      status_nxt  = ST_WRITTEN;
      hit_out_nxt = slot_in_range ? slot_r : 4'd0;
    end else begin
      res_nxt = crc_r;
      if (!found_r) begin
        status_nxt = ST_UNKNOWN;
      end else begin
        hit_out_nxt = 4'(hit_r);
        priority if (flen_r != length_r[hit_r]) begin
          status_nxt = ST_LENGTH;
          expv_nxt   = 8'(length_r[hit_r]);
        end else if (byte0_r != seq_r[hit_r]) begin
          status_nxt = ST_COUNTER;
          expv_nxt   = seq_r[hit_r];
        end else if (crc_r != 8'd0) begin
          status_nxt = ST_CRC;
        end else if (time_ok) begin
          status_nxt = ST_OK;
          commit     = 1'b1;
        end else begin
          status_nxt = ST_TIMING;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (cmd.finish && mode_r && slot_in_range) begin
      valid_r[slot_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (mode_r && slot_in_range) begin
        ident_r[slot_idx]  <= nid_r;
        length_r[slot_idx] <= nlen_r;
        period_r[slot_idx] <= nper_r;
        seq_r[slot_idx]    <= 8'd0;
        last_r[slot_idx]   <= 32'd0;
      end else if (commit) begin
        seq_r[hit_r]  <= seq_r[hit_r] + 8'd1;
        last_r[hit_r] <= now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status_r  <= status_nxt;
      hit_out_r <= hit_out_nxt;
      expv_r    <= expv_nxt;
      res_r     <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_hit_slot       = hit_out_r;
  assign out_expected_value = expv_r;
  assign out_crc_residue    = res_r;

  a_found_is_match: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> valid_r[hit_r] && ident_r[hit_r] == fid_r)
    else $error("recorded hit does not match the frame identifier");

  a_crc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.run_step |-> crc_cnt_r <= MAX_CRC_BYTES && crc_total_r <= MAX_CRC_BYTES)
    else $error("crc byte count past eight");

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while held");

  a_commit_checked: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && commit |-> found_r && crc_r == 8'd0 && !mode_r)
    else $error("table updated by a failing frame");

endmodule

[sv/can_frame_intrusion_checker.sv]
// Checks each received CAN frame against a 16-entry table of known messages
// (identifier, length, rolling counter, CRC-8 over the data, arrival window) and
// returns one result item per input item. For a check item the table is searched
// one entry per cycle and stops at the first match; the CRC runs one data byte per
// cycle alongside it (at most 8). When both are done, a scale state forms the timing
// window and a decide state forms the result. An unknown identifier or a hit in the
// last entry searches the whole table. A table write item goes from run to decide.
// The result sits in an output register, so the next item is accepted while
// it waits to be taken; that item's result waits until the register is free.
// depends on cfic_pkg, cfic_ctrl, cfic_datapath
module can_frame_intrusion_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [3:0]  in_slot,
  input  logic [10:0] in_frame_id,
  input  logic [3:0]  in_frame_len,
  input  logic [63:0] in_frame_data,
  input  logic [31:0] in_now_ms,
  input  logic [10:0] in_new_id,
  input  logic [3:0]  in_new_len,
  input  logic [15:0] in_new_period,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [3:0]  out_hit_slot,
  output logic [7:0]  out_expected_value,
  output logic [7:0]  out_crc_residue
);
  import cfic_pkg::*;

  cfic_cmd_t cmd;
  cfic_sts_t sts;

  cfic_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cfic_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_mode            (in_mode),
    .in_slot            (in_slot),
    .in_frame_id        (in_frame_id),
    .in_frame_len       (in_frame_len),
    .in_frame_data      (in_frame_data),
    .in_now_ms          (in_now_ms),
    .in_new_id          (in_new_id),
    .in_new_len         (in_new_len),
    .in_new_period      (in_new_period),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_hit_slot       (out_hit_slot),
    .out_expected_value (out_expected_value),
    .out_crc_residue    (out_crc_residue)
  );

endmodule
